[rtl/core/positional_list_engine_core_defines.svh]
// Assertion macros for the list engine checker.
// Each expects clk and rst_n in the scope where it is used.
`ifndef POSITIONAL_LIST_ENGINE_CORE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_CORE_DEFINES_SVH

// same-cycle implication
`define PLM_CHECK_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PLM_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/plm_pkg.sv]
package plm_pkg;

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_BACK  = 3'd4,
        CMD_DEL_AT    = 3'd5,
        CMD_READ_ALL  = 3'd6,
        CMD_COUNT     = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 6;
    localparam int unsigned POS_W   = 6;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] value;
        logic [COUNT_W-1:0]       count;
        status_t                  status;
        logic                     last;
    } res_t;

endpackage

[rtl/core/plm_ram.sv]
module plm_ram #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5,
    parameter int unsigned DW    = 32
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/plm_ctrl.sv]
module plm_ctrl #(
    parameter int unsigned CAPACITY = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [2:0]                         command,
    input  logic [plm_pkg::POS_W-1:0]          position,
    input  logic signed [plm_pkg::DATA_W-1:0]  value,
    input  logic                               slot_free,
    output plm_pkg::res_t                      res
);
    import plm_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_INS_RD   = 9'b000000010,
        S_INS_WR   = 9'b000000100,
        S_INS_PUT  = 9'b000001000,
        S_DEL_CAP  = 9'b000010000,
        S_DEL_RD   = 9'b000100000,
        S_DEL_WR   = 9'b001000000,
        S_DUMP_CAP = 9'b010000000,
        S_EMIT     = 9'b100000000
    } state_t;

    state_t                   state_reg, state_next;
    logic [AW-1:0]            head_reg, head_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            cur_reg, cur_next;
    logic [CW-1:0]            stop_reg, stop_next;
    logic signed [DATA_W-1:0] hold_reg, hold_next;
    cmd_t                     mode_reg, mode_next;
    logic signed [DATA_W-1:0] res_val_reg, res_val_next;
    status_t                  res_status_reg, res_status_next;
    logic                     res_last_reg, res_last_next;

    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [DATA_W-1:0]        wr_data;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic [DATA_W-1:0]        rd_data;

    cmd_t                     cmd;
    logic                     full;
    logic                     empty;
    logic                     pos_ok_ins;
    logic                     pos_ok_del;
    logic [CW-1:0]            idx;

    // logical slot to memory address, ring starts at head
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [CW-1:0] ofs);
        logic [AW+1:0] sum;
        sum = (AW+2)'(base) + (AW+2)'(ofs);
        if (sum >= (AW+2)'(CAPACITY))
        begin
            sum = sum - (AW+2)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    plm_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (DATA_W)
    ) u_plm_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cmd        = cmd_t'(command);
    assign full       = (count_reg == CW'(CAPACITY));
    assign empty      = (count_reg == '0);
    assign pos_ok_ins = (position != '0) && (8'(position) <= 8'(count_reg) + 8'd1);
    assign pos_ok_del = (position != '0) && (8'(position) <= 8'(count_reg));
    assign idx        = CW'(position - POS_W'(1));

    assign in_ready   = (state_reg == S_IDLE);

    assign res.valid  = (state_reg == S_EMIT);
    assign res.value  = res_val_reg;
    assign res.count  = COUNT_W'(count_reg);
    assign res.status = res_status_reg;
    assign res.last   = res_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        stop_next       = stop_reg;
        hold_next       = hold_reg;
        mode_next       = mode_reg;
        res_val_next    = res_val_reg;
        res_status_next = res_status_reg;
        res_last_next   = res_last_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        rd_en           = 1'b0;
        rd_addr         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next       = cmd;
                    res_val_next    = '0;
                    res_last_next   = 1'b1;
                    res_status_next = ST_OK;
                    state_next      = S_EMIT;
                    case (cmd)
                        CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT:
                        begin
                            if (full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else if (cmd == CMD_INS_AT && !pos_ok_ins)
                            begin
                                res_status_next = ST_BADPOS;
                            end
                            else if (cmd == CMD_INS_FRONT)
                            begin
                                head_next  = (head_reg == '0) ? AW'(CAPACITY - 1)
                                                              : AW'(head_reg - 1'b1);
                                wr_en      = 1'b1;
                                wr_addr    = head_next;
                                wr_data    = value;
                                count_next = CW'(count_reg + 1'b1);
                            end
                            else if (cmd == CMD_INS_BACK || idx == count_reg)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = phys(head_reg, count_reg);
                                wr_data    = value;
                                count_next = CW'(count_reg + 1'b1);
                            end
                            else
                            begin
                                hold_next  = value;
                                cur_next   = count_reg;
                                stop_next  = idx;
                                state_next = S_INS_RD;
                            end
                        end
                        CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT:
                        begin
                            if (empty)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else if (cmd == CMD_DEL_AT && !pos_ok_del)
                            begin
                                res_status_next = ST_BADPOS;
                            end
                            else
                            begin
                                rd_en = 1'b1;
                                if (cmd == CMD_DEL_FRONT)
                                begin
                                    cur_next = '0;
                                end
                                else if (cmd == CMD_DEL_BACK)
                                begin
                                    cur_next = CW'(count_reg - 1'b1);
                                end
                                else
                                begin
                                    cur_next = idx;
                                end
                                rd_addr    = phys(head_reg, cur_next);
                                state_next = S_DEL_CAP;
                            end
                        end
                        CMD_READ_ALL:
                        begin
                            if (empty)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                cur_next   = '0;
                                state_next = S_DUMP_CAP;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = phys(head_reg, CW'(cur_reg - 1'b1));
                state_next = S_INS_WR;
            end
            S_INS_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = phys(head_reg, cur_reg);
                wr_data  = rd_data;
                cur_next = CW'(cur_reg - 1'b1);
                if (cur_next == stop_reg)
                begin
                    state_next = S_INS_PUT;
                end
                else
                begin
                    state_next = S_INS_RD;
                end
            end
            S_INS_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = phys(head_reg, stop_reg);
                wr_data    = hold_reg;
                count_next = CW'(count_reg + 1'b1);
                state_next = S_EMIT;
            end
            S_DEL_CAP:
            begin
                res_val_next = signed'(rd_data);
                if (mode_reg == CMD_DEL_FRONT)
                begin
                    head_next  = (head_reg == AW'(CAPACITY - 1)) ? '0
                                                                 : AW'(head_reg + 1'b1);
                    count_next = CW'(count_reg - 1'b1);
                    state_next = S_EMIT;
                end
                else if (mode_reg == CMD_DEL_BACK
                         || (CW+1)'(cur_reg) + (CW+1)'(1) >= (CW+1)'(count_reg))
                begin
                    count_next = CW'(count_reg - 1'b1);
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_DEL_RD;
                end
            end
            S_DEL_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = phys(head_reg, CW'(cur_reg + 1'b1));
                state_next = S_DEL_WR;
            end
            S_DEL_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = phys(head_reg, cur_reg);
                wr_data  = rd_data;
                cur_next = CW'(cur_reg + 1'b1);
                if ((CW+1)'(cur_reg) + (CW+1)'(2) < (CW+1)'(count_reg))
                begin
                    state_next = S_DEL_RD;
                end
                else
                begin
                    count_next = CW'(count_reg - 1'b1);
                    state_next = S_EMIT;
                end
            end
            S_DUMP_CAP:
            begin
                res_val_next  = signed'(rd_data);
                res_last_next = ((CW+1)'(cur_reg) + (CW+1)'(1) == (CW+1)'(count_reg));
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    if (mode_reg == CMD_READ_ALL && !res_last_reg)
                    begin
                        cur_next   = CW'(cur_reg + 1'b1);
                        rd_en      = 1'b1;
                        rd_addr    = phys(head_reg, cur_next);
                        state_next = S_DUMP_CAP;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            cur_reg    <= '0;
            stop_reg   <= '0;
            mode_reg   <= CMD_COUNT;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            cur_reg    <= cur_next;
            stop_reg   <= stop_next;
            mode_reg   <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg       <= hold_next;
        res_val_reg    <= res_val_next;
        res_status_reg <= res_status_next;
        res_last_reg   <= res_last_next;
    end

endmodule

[rtl/core/positional_list_engine_core.sv]
// channel | direction | handshake            | payload
// --------+-----------+----------------------+----------------------------------------------
// in      | input     | in_valid / in_ready  | command, position, value
// out     | output    | out_valid / out_ready| item_value, element_count, status, last_result
//
// Count, rejected commands and insert front/back/tail go straight to the result.
// Insert at position p shifts the elements from p onward up by one, and delete at p
// shifts the elements after p down by one; delete front/back read one element.
// Each element move is one read/write pair on the ring memory; read-all reads the
// elements in order, one registered read each.
// No clearing pass after reset; list starts empty at once.
// A stalled out channel holds the engine once its output register is full.
module positional_list_engine_core #(
    parameter int unsigned CAPACITY = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [2:0]                         command,
    input  logic [plm_pkg::POS_W-1:0]          position,
    input  logic signed [plm_pkg::DATA_W-1:0]  value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [plm_pkg::DATA_W-1:0]  item_value,
    output logic [plm_pkg::COUNT_W-1:0]        element_count,
    output logic [1:0]                         status,
    output logic                               last_result
);
    import plm_pkg::*;

    res_t                     res;
    logic                     slot_free;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] item_value_reg;
    logic [COUNT_W-1:0]       element_count_reg;
    status_t                  status_reg;
    logic                     last_result_reg;

    plm_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_plm_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .position  (position),
        .value     (value),
        .slot_free (slot_free),
        .res       (res)
    );

    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && res.valid)
        begin
            item_value_reg    <= res.value;
            element_count_reg <= res.count;
            status_reg        <= res.status;
            last_result_reg   <= res.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign item_value    = item_value_reg;
    assign element_count = element_count_reg;
    assign status        = status_reg;
    assign last_result   = last_result_reg;

endmodule

[rtl/core/plm_checker.sv]
`include "positional_list_engine_core_defines.svh"

module plm_checker #(
    parameter int unsigned CAPACITY = 32
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [plm_pkg::DATA_W-1:0]  item_value,
    input logic [plm_pkg::COUNT_W-1:0]        element_count,
    input logic [1:0]                         status,
    input logic                               last_result
);
    import plm_pkg::*;

    // stalled transfer holds its value, status and last flag
    `PLM_CHECK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(item_value) && $stable(status) && $stable(last_result), "out payload changed while stalled")

    // only read-all streams several results, and those are all ok
    `PLM_CHECK_SAME(a_mid_ok, out_valid && !last_result, status == ST_OK, "non-final result without ok status")

    // full means the count sits at capacity
    `PLM_CHECK_SAME(a_full_count, out_valid && status == ST_FULL, element_count == COUNT_W'(CAPACITY), "full status with wrong count")

    // empty reports zero count and zero value
    `PLM_CHECK_SAME(a_empty_zero, out_valid && status == ST_EMPTY, element_count == '0 && item_value == '0 && last_result, "empty status with stale data")

endmodule

bind positional_list_engine_core plm_checker #(.CAPACITY(CAPACITY)) u_plm_checker (.*);

[dv/positional_list_engine_core_tb.sv]
module positional_list_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import plm_pkg::*;

    localparam int LIST_CAP    = 32;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 100;
    localparam int MAX_PRINTS  = 40;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic [COUNT_W-1:0]       count;
        status_t                  status;
        logic                     last;
    } list_result_t;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_BURSTY} rx_mode_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [2:0]                command;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  value;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [DATA_W-1:0]  item_value;
    logic [COUNT_W-1:0]        element_count;
    logic [1:0]                status;
    logic                      last_result;

    logic signed [DATA_W-1:0] list_model[$];
    list_result_t             pending_results[$];

    int mismatches;
    int commands_sent;
    int results_checked;
    int peak_len;
    int status_hits[4];
    int burst_left;
    int idle_cycles;

    rx_mode_t rx_mode;
    int       rx_mode_left;
    int       rx_period;
    int       rx_phase;
    int       rx_hold;

    positional_list_engine_core #(
        .CAPACITY(LIST_CAP)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .position      (position),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .item_value    (item_value),
        .element_count (element_count),
        .status        (status),
        .last_result   (last_result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("%0t ns: %s", $time, msg);
    endtask

    function automatic void push_result(logic signed [DATA_W-1:0] val, status_t st,
                                        logic last);
        list_result_t r;
        r.value  = val;
        r.count  = COUNT_W'(list_model.size());
        r.status = st;
        r.last   = last;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_command(cmd_t cmd, logic [POS_W-1:0] pos,
                                            logic signed [DATA_W-1:0] val);
        int len;
        int idx;
        logic signed [DATA_W-1:0] taken;
        len = list_model.size();
        case (cmd)
            CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT:
            begin
                if (len >= LIST_CAP)
                    push_result('0, ST_FULL, 1'b1);
                else if (cmd == CMD_INS_AT && (pos < 1 || pos > len + 1))
                    push_result('0, ST_BADPOS, 1'b1);
                else
                begin
                    idx = (cmd == CMD_INS_FRONT) ? 0 : (cmd == CMD_INS_BACK) ? len : pos - 1;
                    list_model.insert(idx, val);
                    push_result('0, ST_OK, 1'b1);
                end
            end
            CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT:
            begin
                if (len == 0)
                    push_result('0, ST_EMPTY, 1'b1);
                else if (cmd == CMD_DEL_AT && (pos < 1 || pos > len))
                    push_result('0, ST_BADPOS, 1'b1);
                else
                begin
                    idx = (cmd == CMD_DEL_FRONT) ? 0 : (cmd == CMD_DEL_BACK) ? len - 1 : pos - 1;
                    taken = list_model[idx];
                    list_model.delete(idx);
                    push_result(taken, ST_OK, 1'b1);
                end
            end
            CMD_READ_ALL:
            begin
                if (len == 0)
                    push_result('0, ST_EMPTY, 1'b1);
                else
                    for (int i = 0; i < len; i++)
                        push_result(list_model[i], ST_OK, i == len - 1);
            end
            default:
                push_result('0, ST_OK, 1'b1);
        endcase
        if (list_model.size() > peak_len)
            peak_len = list_model.size();
    endfunction

    task automatic send_command(cmd_t cmd, int pos, logic signed [DATA_W-1:0] val);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 50)
                                                      : $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        in_valid = 1'b1;
        command  = cmd;
        position = pos[POS_W-1:0];
        value    = val;
        do
            @(posedge clk);
        while (!in_ready);
        burst_left--;
        commands_sent++;
        predict_command(cmd, pos[POS_W-1:0], val);
    endtask

    // hold the input side until every expected result has arrived
    task automatic settle_list();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        burst_left = 0;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_position(cmd_t cmd);
        int len;
        int r;
        len = list_model.size();
        r = $urandom_range(0, 9);
        if (cmd != CMD_INS_AT && cmd != CMD_DEL_AT)
            return $urandom_range(0, 63);
        if (r == 7)
            return 0;
        if (r == 8)
            return (cmd == CMD_INS_AT) ? len + 2 : len + 1;
        if (r == 9)
            return $urandom_range(0, 63);
        if (cmd == CMD_INS_AT)
            return $urandom_range(1, len + 1);
        return $urandom_range(1, (len > 0) ? len : 1);
    endfunction

    function automatic cmd_t pick_insert();
        case ($urandom_range(0, 2))
            0:       return CMD_INS_FRONT;
            1:       return CMD_INS_BACK;
            default: return CMD_INS_AT;
        endcase
    endfunction

    function automatic cmd_t pick_delete();
        case ($urandom_range(0, 2))
            0:       return CMD_DEL_FRONT;
            1:       return CMD_DEL_BACK;
            default: return CMD_DEL_AT;
        endcase
    endfunction

    function automatic cmd_t pick_command(int ins_w, int del_w);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_w)
            return pick_insert();
        if (r < ins_w + del_w)
            return pick_delete();
        return ($urandom_range(0, 4) < 2) ? CMD_READ_ALL : CMD_COUNT;
    endfunction

    task automatic test_empty_list();
        send_command(CMD_DEL_FRONT, 0, 32'h12345678);
        send_command(CMD_DEL_BACK, 63, '1);
        send_command(CMD_DEL_AT, 1, '0);
        send_command(CMD_DEL_AT, 0, '0);
        send_command(CMD_DEL_AT, 63, '0);
        send_command(CMD_READ_ALL, 0, '0);
        send_command(CMD_COUNT, 0, '0);
        send_command(CMD_INS_AT, 0, 32'h0badf00d);
        send_command(CMD_INS_AT, 2, 32'h0badf00d);
        settle_list();
    endtask

    task automatic test_edge_values();
        send_command(CMD_INS_AT, 1, 32'h7fffffff);
        send_command(CMD_INS_FRONT, 0, 32'h80000000);
        send_command(CMD_INS_BACK, 0, '1);
        send_command(CMD_INS_AT, list_model.size() + 1, '0);
        send_command(CMD_INS_AT, 2, 32'h55555555);
        send_command(CMD_INS_AT, list_model.size() + 2, 32'haaaaaaaa);
        send_command(CMD_INS_FRONT, 63, 32'h2aaaaaaa);
        send_command(CMD_READ_ALL, 42, '0);
        send_command(CMD_DEL_AT, list_model.size() + 1, '0);
        send_command(CMD_DEL_AT, 3, '0);
        send_command(CMD_DEL_AT, list_model.size(), '0);
        send_command(CMD_DEL_FRONT, 21, '0);
        send_command(CMD_DEL_BACK, 0, '0);
        send_command(CMD_COUNT, 42, '1);
        send_command(CMD_READ_ALL, 0, '0);
        settle_list();
    endtask

    task automatic test_full_list();
        cmd_t cmd;
        while (list_model.size() < LIST_CAP)
        begin
            cmd = pick_insert();
            send_command(cmd, $urandom_range(1, list_model.size() + 1), pick_value());
        end
        send_command(CMD_INS_FRONT, 0, 32'h11111111);
        send_command(CMD_INS_BACK, 0, 32'h22222222);
        send_command(CMD_INS_AT, LIST_CAP + 1, 32'h33333333);
        send_command(CMD_INS_AT, 0, 32'h44444444);
        send_command(CMD_INS_AT, 1, 32'h55555555);
        send_command(CMD_READ_ALL, 0, '0);
        send_command(CMD_COUNT, 0, '0);
        send_command(CMD_DEL_AT, LIST_CAP + 1, '0);
        send_command(CMD_DEL_AT, LIST_CAP, '0);
        send_command(CMD_INS_AT, 1, 32'h66666666);
        settle_list();
        while (list_model.size() > 0)
        begin
            cmd = pick_delete();
            send_command(cmd, $urandom_range(1, list_model.size()), '0);
        end
        send_command(CMD_DEL_BACK, 0, '0);
        send_command(CMD_READ_ALL, 0, '0);
        settle_list();
    endtask

    task automatic test_random_traffic(int n, int ins_w, int del_w);
        cmd_t cmd;
        for (int k = 0; k < n; k++)
        begin
            cmd = pick_command(ins_w, del_w);
            send_command(cmd, pick_position(cmd), pick_value());
        end
        settle_list();
    endtask

    // receiver: changes its stall behavior every so often
    always @(negedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode      = rx_mode_t'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 150);
            rx_period    = $urandom_range(2, 6);
            rx_phase     = 0;
            rx_hold      = 0;
        end
        rx_mode_left--;
        case (rx_mode)
            RX_ALWAYS:
                out_ready = 1'b1;
            RX_RANDOM:
                out_ready = ($urandom_range(0, 1) == 1);
            RX_PERIODIC:
            begin
                out_ready = (rx_phase == 0);
                rx_phase  = (rx_phase + 1) % rx_period;
            end
            default:
            begin
                if (rx_hold > 0)
                begin
                    rx_hold--;
                    out_ready = 1'b0;
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    rx_hold   = $urandom_range(5, 12);
                    out_ready = 1'b0;
                end
                else
                    out_ready = 1'b1;
            end
        endcase
    end

    always @(posedge clk)
    begin
        list_result_t exp;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result value=%0d count=%0d status=%0d",
                                          item_value, element_count, status));
            else
            begin
                exp = pending_results.pop_front();
                results_checked++;
                status_hits[exp.status]++;
                if (item_value !== exp.value)
                    report_mismatch($sformatf("item_value %0d, expected %0d",
                                              item_value, exp.value));
                if (element_count !== exp.count)
                    report_mismatch($sformatf("element_count %0d, expected %0d",
                                              element_count, exp.count));
                if (status !== exp.status)
                    report_mismatch($sformatf("status %0d, expected %s",
                                              status, exp.status.name()));
                if (last_result !== exp.last)
                    report_mismatch($sformatf("last_result %0b, expected %0b",
                                              last_result, exp.last));
            end
        end
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, pending_results.size());
                $display("positional_list_engine_core: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        command      = CMD_COUNT;
        position     = '0;
        value        = '0;
        out_ready    = 1'b0;
        mismatches   = 0;
        commands_sent = 0;
        results_checked = 0;
        peak_len     = 0;
        burst_left   = 0;
        idle_cycles  = 0;
        rx_mode      = RX_ALWAYS;
        rx_mode_left = 0;
        rx_period    = 2;
        rx_phase     = 0;
        rx_hold      = 0;
        for (int i = 0; i < 4; i++)
            status_hits[i] = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_list();
        test_edge_values();
        test_full_list();
        test_random_traffic(130, 60, 25);
        test_random_traffic(100, 15, 70);
        test_random_traffic(120, 40, 40);

        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d commands and %0d results, list length up to %0d of %0d",
                 commands_sent, results_checked, peak_len, LIST_CAP);
        $display("statuses seen: ok %0d, empty %0d, full %0d, bad position %0d",
                 status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_FULL],
                 status_hits[ST_BADPOS]);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("positional_list_engine_core: match");
        else
            $display("positional_list_engine_core: mismatch");
        $finish;
    end

endmodule
